// ----- rtl/modbus_rtu_read_response_parser_defines.svh -----
// assertion macros for the modbus rtu read response parser
// clocked on clk_i, disabled while rst_ni is low; define NO_ASSERTIONS to drop them
`ifndef MODBUS_RTU_READ_RESPONSE_PARSER_DEFINES_SVH
`define MODBUS_RTU_READ_RESPONSE_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MRRP_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define MRRP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define MRRP_ASSERT(lbl, expr, msg)
`define MRRP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/mrrp_pkg.sv -----
// shared constants and types of the modbus rtu read response parser
// no dependencies
package mrrp_pkg;

  localparam int MAX_REGISTERS = 32;
  localparam int BUF_BYTES     = 2 * MAX_REGISTERS;
  localparam int BUF_AW        = $clog2(BUF_BYTES);

  localparam logic [8:0]  SEEN_MAX  = 9'd511;
  localparam logic [8:0]  MIN_LEN   = 9'd5;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FC_READ   = 8'h03;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_FUNCTION  = 3'd2;
  localparam logic [2:0] ST_LENGTH    = 3'd3;
  localparam logic [2:0] ST_CRC       = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       step;
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

// ----- rtl/mrrp_ram.sv -----
// generic single-port ram with registered read data
// no dependencies
module mrrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mrrp_crc.sv -----
// bit-serial crc-16/modbus: load xors a byte in, each step shifts one bit
// depends on mrrp_pkg
module mrrp_crc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mrrp_pkg::crc_ctrl_t ctrl_i,
  output logic [15:0]         crc_o
);

  logic [15:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    priority if (ctrl_i.clear) begin
      crc_d = mrrp_pkg::CRC_INIT;
    end else if (ctrl_i.load) begin
      crc_d = crc_q ^ {8'h00, ctrl_i.data};
    end else if (ctrl_i.step) begin
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ mrrp_pkg::CRC_POLY) : (crc_q >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= mrrp_pkg::CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// ----- rtl/modbus_rtu_read_response_parser.sv -----
// modbus rtu read holding registers response parser, one frame byte per item
// byte flow: from the third byte on, accepting a byte loads the byte two back into the crc (bit-serial, 8 steps)
// end of frame: crc steps, a judge state, then per register the states rd_hi, rd_lo and emit (two ram reads)
// a status-only result appears in the cycle after the judge state; results are registered
// reset: frame state cleared, crc 0xFFFF; the data buffer ram is not cleared
module modbus_rtu_read_response_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  frame_byte_i,
  input  logic        end_of_frame_i,
  output logic        strobe_o,
  output logic [2:0]  status_o,
  output logic [15:0] register_value_o,
  output logic [5:0]  register_index_o,
  output logic        register_present_o,
  output logic        last_of_run_o
);

`include "modbus_rtu_read_response_parser_defines.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CRC   = 3'd1;
  localparam logic [2:0] S_JUDGE = 3'd2;
  localparam logic [2:0] S_RD_HI = 3'd3;
  localparam logic [2:0] S_RD_LO = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic [8:0]  seen_q, seen_d;
  logic [15:0] delay_q, delay_d;
  logic [7:0]  func_q, func_d;
  logic [7:0]  count_q, count_d;
  logic        eof_q, eof_d;
  logic [5:0]  idx_q, idx_d;
  logic [7:0]  hi_q, hi_d;

  logic        strobe_q, strobe_d;
  logic [2:0]  status_q, status_d;
  logic [15:0] value_q, value_d;
  logic [5:0]  index_q, index_d;
  logic        present_q, present_d;
  logic        last_q, last_d;

  logic                        accept;
  logic                        ram_we;
  logic [mrrp_pkg::BUF_AW-1:0] ram_addr;
  logic [7:0]                  ram_rdata;
  logic [8:0]                  data_pos;
  logic [15:0]                 crc;
  logic [15:0]                 recv_crc;
  logic [6:0]                  regs;
  logic [2:0]                  verdict;
  logic                        last_reg;
  mrrp_pkg::crc_ctrl_t         crc_ctrl;

  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign data_pos = seen_q - 9'd3;
  assign recv_crc = {delay_q[7:0], delay_q[15:8]};
  assign regs     = count_q[7:1];
  assign last_reg = (({1'b0, idx_q} + 7'd1) == regs);

  always_comb begin
    priority if (seen_q < mrrp_pkg::MIN_LEN) begin
      verdict = mrrp_pkg::ST_SHORT;
    end else if (func_q != mrrp_pkg::FC_READ) begin
      verdict = mrrp_pkg::ST_FUNCTION;
    end else if (seen_q != (mrrp_pkg::MIN_LEN + {1'b0, count_q})) begin
      verdict = mrrp_pkg::ST_LENGTH;
    end else if (crc != recv_crc) begin
      verdict = mrrp_pkg::ST_CRC;
    end else if (regs > 7'(mrrp_pkg::MAX_REGISTERS)) begin
      verdict = mrrp_pkg::ST_OVERFLOW;
    end else begin
      verdict = mrrp_pkg::ST_OK;
    end
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    seen_d    = seen_q;
    delay_d   = delay_q;
    func_d    = func_q;
    count_d   = count_q;
    eof_d     = eof_q;
    idx_d     = idx_q;
    hi_d      = hi_q;
    strobe_d  = 1'b0;
    status_d  = status_q;
    value_d   = value_q;
    index_d   = index_q;
    present_d = present_q;
    last_d    = last_q;
    ram_we    = 1'b0;
    ram_addr  = data_pos[mrrp_pkg::BUF_AW-1:0];
    crc_ctrl  = '{clear: 1'b0, load: 1'b0, step: 1'b0, data: delay_q[15:8]};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          delay_d = {delay_q[7:0], frame_byte_i};
          eof_d   = end_of_frame_i;
          step_d  = 3'd0;
          if (seen_q == 9'd1) begin
            func_d = frame_byte_i;
          end else if (seen_q == 9'd2) begin
            count_d = frame_byte_i;
          end else if (seen_q >= 9'd3 && data_pos < 9'(mrrp_pkg::BUF_BYTES)) begin
            ram_we = 1'b1;
          end
          if (seen_q < mrrp_pkg::SEEN_MAX) begin
            seen_d = seen_q + 9'd1;
          end
          // the byte two back leaves the delay line and enters the crc
          if (seen_q >= 9'd2) begin
            crc_ctrl.load = 1'b1;
            state_d       = S_CRC;
          end else if (end_of_frame_i) begin
            state_d = S_JUDGE;
          end
        end
      end
      S_CRC: begin
        crc_ctrl.step = 1'b1;
        step_d        = step_q + 3'd1;
        if (step_q == 3'd7) begin
          state_d = eof_q ? S_JUDGE : S_IDLE;
        end
      end
      S_JUDGE: begin
        idx_d = '0;
        if (verdict != mrrp_pkg::ST_OK || regs == 7'd0) begin
          strobe_d  = 1'b1;
          status_d  = verdict;
          value_d   = '0;
          index_d   = '0;
          present_d = 1'b0;
          last_d    = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_RD_HI;
        end
      end
      S_RD_HI: begin
        ram_addr = mrrp_pkg::BUF_AW'({idx_q, 1'b0});
        state_d  = S_RD_LO;
      end
      S_RD_LO: begin
        ram_addr = mrrp_pkg::BUF_AW'({idx_q, 1'b1});
        hi_d     = ram_rdata;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        strobe_d  = 1'b1;
        status_d  = mrrp_pkg::ST_OK;
        value_d   = {hi_q, ram_rdata};
        index_d   = idx_q;
        present_d = 1'b1;
        last_d    = last_reg;
        idx_d     = idx_q + 6'd1;
        state_d   = last_reg ? S_IDLE : S_RD_HI;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // frame done: return frame state to reset values
    if (strobe_d && last_d) begin
      seen_d         = '0;
      delay_d        = '0;
      func_d         = '0;
      count_d        = '0;
      crc_ctrl.clear = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      seen_q   <= '0;
      delay_q  <= '0;
      func_q   <= '0;
      count_q  <= '0;
      eof_q    <= 1'b0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      seen_q   <= seen_d;
      delay_q  <= delay_d;
      func_q   <= func_d;
      count_q  <= count_d;
      eof_q    <= eof_d;
      idx_q    <= idx_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q      <= hi_d;
    status_q  <= status_d;
    value_q   <= value_d;
    index_q   <= index_d;
    present_q <= present_d;
    last_q    <= last_d;
  end

  mrrp_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc)
  );

  mrrp_ram #(
    .WIDTH (8),
    .DEPTH (mrrp_pkg::BUF_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (frame_byte_i),
    .rdata_o (ram_rdata)
  );

  assign strobe_o           = strobe_q;
  assign status_o           = status_q;
  assign register_value_o   = value_q;
  assign register_index_o   = index_q;
  assign register_present_o = present_q;
  assign last_of_run_o      = last_q;

  `MRRP_ASSERT_IMPL(a_strobe_src, strobe_o, $past(state_q == S_JUDGE || state_q == S_EMIT),
                    "result strobe without judge or emit cycle")
  `MRRP_ASSERT_IMPL(a_run_busy, strobe_o && !last_of_run_o, busy,
                    "parser idle in the middle of a register run")
  `MRRP_ASSERT_IMPL(a_present_ok, strobe_o && register_present_o, status_o == mrrp_pkg::ST_OK,
                    "register carried with a failing status")
  `MRRP_ASSERT_IMPL(a_write_accept, ram_we, accept,
                    "buffer written without an accepted item")

endmodule

// ----- tb/tb_modbus_rtu_read_response_parser.sv -----
// testbench for the modbus rtu read response parser: sends response frames byte by byte
// and checks every register or status item against a built-in frame parser model
// depends on mrrp_pkg and the modbus_rtu_read_response_parser top level
`timescale 1ns / 1ps

module tb_modbus_rtu_read_response_parser;

  // random frames fill the run up to about this many bytes
  localparam int BYTE_BUDGET = 440;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] value;
    logic [5:0]  index;
    logic        present;
    logic        last;
  } reg_item_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic [7:0]  frame_byte_i   = 8'h00;
  logic        end_of_frame_i = 1'b0;
  logic        busy;
  logic        strobe_o;
  logic [2:0]  status_o;
  logic [15:0] register_value_o;
  logic [5:0]  register_index_o;
  logic        register_present_o;
  logic        last_of_run_o;

  modbus_rtu_read_response_parser u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .frame_byte_i       (frame_byte_i),
    .end_of_frame_i     (end_of_frame_i),
    .strobe_o           (strobe_o),
    .status_o           (status_o),
    .register_value_o   (register_value_o),
    .register_index_o   (register_index_o),
    .register_present_o (register_present_o),
    .last_of_run_o      (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser model state
  logic [8:0]  seen_cnt  = '0;
  logic [15:0] crc_acc   = mrrp_pkg::CRC_INIT;
  logic [15:0] held_pair = '0;
  logic [7:0]  func_code = '0;
  logic [7:0]  byte_cnt  = '0;
  logic [7:0]  data_mem [mrrp_pkg::BUF_BYTES];

  reg_item_t  expected_regs_q[$];
  logic [7:0] frame_q[$];

  int err_cnt       = 0;
  int bytes_sent    = 0;
  int frames_sent   = 0;
  int reg_results   = 0;
  int status_results = 0;
  int burst_left    = 0;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ mrrp_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // update the parser model with one accepted byte, queue what the frame end yields
  function automatic void parse_byte(logic [7:0] b, logic eof);
    logic [8:0]  pos;
    logic [15:0] recv;
    logic [2:0]  st;
    int          regs;
    reg_item_t   it;
    pos = seen_cnt;
    // crc lags two bytes so the trailing crc itself is never folded in
    if (pos >= 2) crc_acc = crc_byte(crc_acc, held_pair[15:8]);
    held_pair = {held_pair[7:0], b};
    if (pos == 1) func_code = b;
    else if (pos == 2) byte_cnt = b;
    else if (pos >= 3 && int'(pos) - 3 < mrrp_pkg::BUF_BYTES) data_mem[int'(pos) - 3] = b;
    if (seen_cnt < mrrp_pkg::SEEN_MAX) seen_cnt = seen_cnt + 9'd1;
    if (!eof) return;
    recv = {held_pair[7:0], held_pair[15:8]};
    regs = int'(byte_cnt) / 2;
    if (seen_cnt < mrrp_pkg::MIN_LEN) st = mrrp_pkg::ST_SHORT;
    else if (func_code != mrrp_pkg::FC_READ) st = mrrp_pkg::ST_FUNCTION;
    else if (int'(seen_cnt) != int'(mrrp_pkg::MIN_LEN) + int'(byte_cnt))
      st = mrrp_pkg::ST_LENGTH;
    else if (crc_acc != recv) st = mrrp_pkg::ST_CRC;
    else if (regs > mrrp_pkg::MAX_REGISTERS) st = mrrp_pkg::ST_OVERFLOW;
    else st = mrrp_pkg::ST_OK;
    if (st != mrrp_pkg::ST_OK || regs == 0) begin
      it = {st, 16'h0000, 6'd0, 1'b0, 1'b1};
      expected_regs_q.push_back(it);
    end else begin
      for (int i = 0; i < regs; i++) begin
        it = {mrrp_pkg::ST_OK, data_mem[2 * i], data_mem[2 * i + 1], 6'(i), 1'b1,
              (i == regs - 1)};
        expected_regs_q.push_back(it);
      end
    end
    seen_cnt  = '0;
    crc_acc   = mrrp_pkg::CRC_INIT;
    held_pair = '0;
    func_code = '0;
    byte_cnt  = '0;
  endfunction

  function automatic void note_mismatch(string what, reg_item_t want, reg_item_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t %s: exp st=%0d val=%h idx=%0d pres=%b last=%b, got st=%0d val=%h idx=%0d pres=%b last=%b",
               $time, what, want.status, want.value, want.index, want.present, want.last,
               got.status, got.value, got.index, got.present, got.last);
  endfunction

  always @(posedge clk_i) begin : check_results
    reg_item_t got, want;
    if (rst_ni && strobe_o) begin
      got = {status_o, register_value_o, register_index_o, register_present_o, last_of_run_o};
      if (got.present) reg_results++;
      else status_results++;
      if (expected_regs_q.size() == 0) begin
        note_mismatch("item with nothing expected", '0, got);
      end else begin
        want = expected_regs_q.pop_front();
        if (got !== want) note_mismatch("item mismatch", want, got);
      end
    end
  end

  // one byte per handshake; start is left high so back-to-back bytes need no toggle
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    start          <= 1'b1;
    frame_byte_i   <= b;
    end_of_frame_i <= eof;
    do @(posedge clk_i); while (busy);
    parse_byte(b, eof);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  // address, function, byte count, data and a valid crc; fill < 0 means random bytes
  task automatic make_frame(input logic [7:0] fc, input int count, input int ndata,
                            input int fill);
    logic [15:0] c;
    frame_q.delete();
    frame_q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0]);
    frame_q.push_back(fc);
    frame_q.push_back(count[7:0]);
    for (int i = 0; i < ndata; i++)
      frame_q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0]);
    c = mrrp_pkg::CRC_INIT;
    foreach (frame_q[i]) c = crc_byte(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  task automatic test_short_frames();
    for (int n = 1; n <= 4; n++) begin
      frame_q.delete();
      for (int i = 0; i < n; i++)
        frame_q.push_back((i == 1) ? mrrp_pkg::FC_READ : 8'($urandom_range(0, 255)));
      send_frame();
    end
  endtask

  task automatic test_good_frames();
    make_frame(mrrp_pkg::FC_READ, 0, 0, -1);
    send_frame();
    // odd count: trailing byte dropped, no register left
    make_frame(mrrp_pkg::FC_READ, 1, 1, -1);
    send_frame();
    make_frame(mrrp_pkg::FC_READ, 2, 2, 0);
    send_frame();
    make_frame(mrrp_pkg::FC_READ, 2, 2, 255);
    send_frame();
    make_frame(mrrp_pkg::FC_READ, 3, 3, -1);
    send_frame();
    make_frame(mrrp_pkg::FC_READ, 12, 12, -1);
    send_frame();
    make_frame(mrrp_pkg::FC_READ, 2 * mrrp_pkg::MAX_REGISTERS, 2 * mrrp_pkg::MAX_REGISTERS, -1);
    send_frame();
  endtask

  task automatic test_wrong_function();
    logic [7:0] codes [4] = '{8'h00, 8'h04, 8'h83, 8'hFF};
    foreach (codes[i]) begin
      make_frame(codes[i], 4, 4, -1);
      send_frame();
    end
  endtask

  task automatic test_length_mismatch();
    make_frame(mrrp_pkg::FC_READ, 4, 3, -1);
    send_frame();
    make_frame(mrrp_pkg::FC_READ, 4, 5, -1);
    send_frame();
    make_frame(mrrp_pkg::FC_READ, 0, 2, -1);
    send_frame();
    make_frame(mrrp_pkg::FC_READ, 255, 10, -1);
    send_frame();
  endtask

  task automatic test_crc_mismatch();
    make_frame(mrrp_pkg::FC_READ, 6, 6, -1);
    frame_q[frame_q.size() - 1] ^= 8'h80;
    send_frame();
    make_frame(mrrp_pkg::FC_READ, 6, 6, -1);
    frame_q[frame_q.size() - 2] ^= 8'h01;
    send_frame();
    make_frame(mrrp_pkg::FC_READ, 6, 6, -1);
    frame_q[4] ^= 8'(1 << $urandom_range(0, 7));
    send_frame();
  endtask

  task automatic test_overflow();
    make_frame(mrrp_pkg::FC_READ, 2 * mrrp_pkg::MAX_REGISTERS + 2,
               2 * mrrp_pkg::MAX_REGISTERS + 2, -1);
    send_frame();
    // full buffer plus an odd byte past its end
    make_frame(mrrp_pkg::FC_READ, 2 * mrrp_pkg::MAX_REGISTERS + 1,
               2 * mrrp_pkg::MAX_REGISTERS + 1, -1);
    send_frame();
  endtask

  task automatic test_random_frames();
    int kind, sel, count, ndata, cut;
    logic [7:0] fc;
    while (bytes_sent < BYTE_BUDGET) begin
      kind  = $urandom_range(0, 99);
      sel   = $urandom_range(0, 19);
      count = (sel < 16) ? $urandom_range(0, 16) :
              (sel < 19) ? $urandom_range(17, 32) : $urandom_range(33, 40);
      if (kind < 60) begin
        make_frame(mrrp_pkg::FC_READ, count, count, -1);
      end else if (kind < 68) begin
        fc = 8'($urandom_range(0, 255));
        if (fc == mrrp_pkg::FC_READ) fc = 8'h83;
        make_frame(fc, count, count, -1);
      end else if (kind < 76) begin
        ndata = $urandom_range(0, 1) ? count + $urandom_range(1, 3) : count - $urandom_range(1, 3);
        if (ndata < 0) ndata = count + 1;
        make_frame(mrrp_pkg::FC_READ, count, ndata, -1);
      end else if (kind < 86) begin
        make_frame(mrrp_pkg::FC_READ, count, count, -1);
        cut = $urandom_range(0, frame_q.size() - 1);
        frame_q[cut] ^= 8'(1 << $urandom_range(0, 7));
      end else if (kind < 94) begin
        make_frame(mrrp_pkg::FC_READ, count, count, -1);
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end else begin
        frame_q.delete();
        repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
      send_frame();
    end
  endtask

  initial begin
    foreach (data_mem[i]) data_mem[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_frames();
    test_good_frames();
    test_wrong_function();
    test_length_mismatch();
    test_crc_mismatch();
    test_overflow();
    test_random_frames();
    start <= 1'b0;
    while (expected_regs_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("sent %0d frames in %0d bytes, good and corrupted, short and overflowing",
             frames_sent, bytes_sent);
    $display("got %0d register items and %0d status items, %0d mismatches",
             reg_results, status_results, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_modbus_rtu_read_response_parser OK");
    end else begin
      $display("tb_modbus_rtu_read_response_parser NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d items still expected", expected_regs_q.size());
    $display("tb_modbus_rtu_read_response_parser NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mrrp_pkg.sv
rtl/mrrp_ram.sv
rtl/mrrp_crc.sv
rtl/modbus_rtu_read_response_parser.sv
tb/tb_modbus_rtu_read_response_parser.sv
